### hw/rtl/assoc_laguerre_polynomial_eval_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the associated Laguerre evaluator
// Clocked on clk_i and held off while rst_ni is low. Define NO_ASSERTIONS to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSOC_LAGUERRE_POLYNOMIAL_EVAL_ASSERT_SVH
`define ASSOC_LAGUERRE_POLYNOMIAL_EVAL_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge.
`define ALAG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("alag: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ALAG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("alag: assertion failed");

`else

`define ALAG_ASSERT(lbl, prop)
`define ALAG_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### hw/rtl/alag_pkg.sv
// ----------------------------------------------------------------------------
// alag_pkg
// Shared constants and types for the associated Laguerre evaluator.
// ----------------------------------------------------------------------------
package alag_pkg;

  localparam int unsigned MAX_DEGREE = 31;
  // One cell per recurrence step i = 2..MAX_DEGREE.
  localparam int unsigned NUM_CELLS  = MAX_DEGREE - 1;
  localparam int unsigned IDX_W      = $clog2(MAX_DEGREE + 1);
  localparam int unsigned CFG_W      = 6;

  typedef enum logic {
    REG_DEGREE = 1'b0,
    REG_ORDER  = 1'b1
  } cfg_reg_e;

  localparam logic signed [63:0] ONE_Q32     = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] NEG_ONE_Q32 = 64'shFFFF_FFFF_0000_0000;

  // Data handed from one cell to the next.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [63:0] cur;
    logic signed [63:0] prev;
    logic               clip;
  } alag_beat_t;

endpackage

### hw/rtl/alag_in_if.sv
// ----------------------------------------------------------------------------
// alag_in_if
// Valid/ready channel carrying one sample point per beat.
// ----------------------------------------------------------------------------
interface alag_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_point;

  modport source (output valid, output sample_point, input ready);
  modport sink   (input valid, input sample_point, output ready);
endinterface

### hw/rtl/alag_out_if.sv
// ----------------------------------------------------------------------------
// alag_out_if
// Valid/ready channel carrying one polynomial value per beat.
// ----------------------------------------------------------------------------
interface alag_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] poly_value;
  logic               saturated;

  modport source (output valid, output poly_value, output saturated, input ready);
  modport sink   (input valid, input poly_value, input saturated, output ready);
endinterface

### hw/rtl/alag_cell.sv
// ----------------------------------------------------------------------------
// alag_cell
// One step of the three-term recurrence, four register stages deep:
// partial products, Q.48 sum with rounding, reciprocal products, then
// final rounding and clipping. Passes the beat unchanged past the degree.
// ----------------------------------------------------------------------------
module alag_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic [alag_pkg::IDX_W-1:0]  stage_i,
  input  logic [31:0]                 recip_i,
  input  logic [alag_pkg::CFG_W-1:0]  order_i,
  input  logic [alag_pkg::IDX_W-1:0]  n_eff_i,
  input  logic                        valid_i,
  input  alag_pkg::alag_beat_t        beat_i,
  output logic                        valid_o,
  output alag_pkg::alag_beat_t        beat_o
);
  import alag_pkg::*;

  logic [3:0] vld_q;

  // stage A: partial products
  logic [6:0]         coef_a;
  logic [6:0]         coef_b;
  logic signed [33:0] a_val;
  logic signed [66:0] plo_d;
  logic signed [65:0] phi_d;
  logic signed [71:0] q_d;
  logic               act_d;
  alag_beat_t         beat_a_q;
  logic               act_a_q;
  logic signed [66:0] plo_a_q;
  logic signed [65:0] phi_a_q;
  logic signed [71:0] q_a_q;

  // stage B: rounded sum in Q.32
  logic signed [99:0] sum_b;
  alag_beat_t         beat_b_q;
  logic               act_b_q;
  logic signed [83:0] sr_b_q;

  // stage C: reciprocal products
  logic [63:0]        pl_d;
  logic [63:0]        pm_d;
  logic signed [52:0] ph_d;
  alag_beat_t         beat_c_q;
  logic               act_c_q;
  logic [63:0]        pl_c_q;
  logic [63:0]        pm_c_q;
  logic signed [52:0] ph_c_q;

  // stage D: round, clip, hand on
  logic signed [117:0] prod_c;
  logic signed [85:0]  shr_c;
  logic                ovf_c;
  logic signed [63:0]  sat_c;
  alag_beat_t          beat_d_d;
  alag_beat_t          beat_d_q;

  always_comb begin
    coef_a = 7'(order_i) + 7'({stage_i, 1'b0}) - 7'd1;
    coef_b = 7'(order_i) + 7'(stage_i) - 7'd1;
    a_val  = $signed({11'b0, coef_a, 16'b0}) - $signed({{2{beat_i.x[31]}}, beat_i.x});
    plo_d  = a_val * $signed({1'b0, beat_i.cur[31:0]});
    phi_d  = a_val * $signed(beat_i.cur[63:32]);
    q_d    = $signed({1'b0, coef_b}) * beat_i.prev;
    act_d  = (stage_i <= n_eff_i);
  end

  always_comb begin
    sum_b = $signed({{2{phi_a_q[65]}}, phi_a_q, 32'b0})
          + $signed({{33{plo_a_q[66]}}, plo_a_q})
          - $signed({{12{q_a_q[71]}}, q_a_q, 16'b0})
          + $signed(100'd32768);
  end

  always_comb begin
    pl_d = {32'b0, sr_b_q[31:0]} * {32'b0, recip_i};
    pm_d = {32'b0, sr_b_q[63:32]} * {32'b0, recip_i};
    ph_d = $signed(sr_b_q[83:64]) * $signed({1'b0, recip_i});
  end

  always_comb begin
    prod_c = $signed({ph_c_q[52], ph_c_q, 64'b0})
           + $signed({22'b0, pm_c_q, 32'b0})
           + $signed({54'b0, pl_c_q})
           + $signed(118'd2147483648);
    shr_c  = prod_c[117:32];
    ovf_c  = (shr_c[85:63] != {23{shr_c[85]}});
    if (!ovf_c) begin
      sat_c = shr_c[63:0];
    end else if (shr_c[85]) begin
      sat_c = {1'b1, 63'b0};
    end else begin
      sat_c = {1'b0, {63{1'b1}}};
    end
    beat_d_d = beat_c_q;
    if (act_c_q) begin
      beat_d_d.prev = beat_c_q.cur;
      beat_d_d.cur  = sat_c;
      beat_d_d.clip = beat_c_q.clip | ovf_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      beat_a_q <= beat_i;
      act_a_q  <= act_d;
      plo_a_q  <= plo_d;
      phi_a_q  <= phi_d;
      q_a_q    <= q_d;
      beat_b_q <= beat_a_q;
      act_b_q  <= act_a_q;
      sr_b_q   <= sum_b[99:16];
      beat_c_q <= beat_b_q;
      act_c_q  <= act_b_q;
      pl_c_q   <= pl_d;
      pm_c_q   <= pm_d;
      ph_c_q   <= ph_d;
      beat_d_q <= beat_d_d;
    end
  end

  assign valid_o = vld_q[3];
  assign beat_o  = beat_d_q;

endmodule

### hw/rtl/assoc_laguerre_polynomial_eval.sv
// ----------------------------------------------------------------------------
// assoc_laguerre_polynomial_eval
// Associated Laguerre polynomial L_n^m(x) over a chain of recurrence cells.
// ----------------------------------------------------------------------------
// Usage:
//   Write degree n (index 0, signed) and order m (index 1) through the
//   cfg_* port while the block is idle. Sample points x (Q16.16) enter on
//   in_i; each yields one beat on out_o with L_n^m(x) in Q32.32 and a flag
//   set when any recurrence step clipped to the 64-bit range.
//   A negative degree returns -1.0, degree zero returns 1.0.
// Occupancy:
//   One item is in the cell chain at a time. A sample passes through the
//   register stages of each of the MAX_DEGREE-1 cells and then the output
//   register, whatever the degree, since the cells past the degree pass the
//   beat along. The block takes no new sample until the result of the last
//   one lands in the output register.
// Reset clears both registers to zero and empties the chain.
// Stall: a result waits in the output register; the chain freezes only when
//   a new result would overwrite one not yet taken.
// ----------------------------------------------------------------------------
`include "assoc_laguerre_polynomial_eval_assert.svh"

module assoc_laguerre_polynomial_eval (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [alag_pkg::CFG_W-1:0] cfg_data_i,
  alag_in_if.sink                    in_i,
  alag_out_if.source                 out_o
);
  import alag_pkg::*;

  logic signed [CFG_W-1:0] degree_q;
  logic [CFG_W-1:0]        order_q;
  logic                    inflight_q;
  logic                    out_valid_q;
  logic signed [63:0]      poly_value_q;
  logic                    saturated_q;

  logic                    adv;
  logic                    in_fire;
  logic                    tail_fire;
  logic [CFG_W-1:0]        deg_mag;
  logic [IDX_W-1:0]        n_eff;
  logic signed [63:0]      l1_val;
  alag_beat_t              head_beat;

  logic [NUM_CELLS:0]      chain_vld;
  alag_beat_t              chain_beat [NUM_CELLS+1];

  // Hold the chain only when a finished beat meets a full, stalled output.
  assign adv       = !(chain_vld[NUM_CELLS] && out_valid_q && !out_o.ready);
  assign in_i.ready = !inflight_q && adv;
  assign in_fire   = in_i.valid && in_i.ready;
  assign tail_fire = chain_vld[NUM_CELLS] && adv;

  always_comb begin
    deg_mag = degree_q;
    if (degree_q[CFG_W-1]) begin
      n_eff = '0;
    end else if (32'(deg_mag) > 32'(MAX_DEGREE)) begin
      n_eff = IDX_W'(MAX_DEGREE);
    end else begin
      n_eff = IDX_W'(deg_mag);
    end
  end

  always_comb begin
    l1_val = $signed({25'b0, 7'({1'b0, order_q}) + 7'd1, 32'b0})
           - $signed({{16{in_i.sample_point[31]}}, in_i.sample_point, 16'b0});
    head_beat.x    = in_i.sample_point;
    head_beat.prev = ONE_Q32;
    head_beat.clip = 1'b0;
    if (degree_q[CFG_W-1]) begin
      head_beat.cur = NEG_ONE_Q32;
    end else if (degree_q == '0) begin
      head_beat.cur = ONE_Q32;
    end else begin
      head_beat.cur = l1_val;
    end
  end

  assign chain_vld[0]  = in_fire;
  assign chain_beat[0] = head_beat;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    localparam int unsigned StageIdx = g + 2;
    localparam logic [31:0] Recip = 32'(((64'd1 << 32) + StageIdx / 2) / StageIdx);

    alag_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .stage_i (IDX_W'(StageIdx)),
      .recip_i (Recip),
      .order_i (order_q),
      .n_eff_i (n_eff),
      .valid_i (chain_vld[g]),
      .beat_i  (chain_beat[g]),
      .valid_o (chain_vld[g+1]),
      .beat_o  (chain_beat[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= '0;
      order_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DEGREE: degree_q <= cfg_data_i;
        REG_ORDER:  order_q  <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        inflight_q <= 1'b1;
      end else if (tail_fire) begin
        inflight_q <= 1'b0;
      end
      if (tail_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail_fire) begin
      poly_value_q <= chain_beat[NUM_CELLS].cur;
      saturated_q  <= chain_beat[NUM_CELLS].clip;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.poly_value = poly_value_q;
  assign out_o.saturated  = saturated_q;

  `ALAG_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready)
  `ALAG_ASSERT(a_tail_needs_inflight, !chain_vld[NUM_CELLS] || inflight_q)
  `ALAG_ASSERT(a_single_item, $countones(chain_vld) <= 1)
  `ALAG_ASSERT(a_freeze_on_stall, !(chain_vld[NUM_CELLS] && out_valid_q && !out_o.ready) || !adv)

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Associated Laguerre evaluator testbench
// Streams Q16.16 sample points through the block under a range of degree and
// order settings. A bit-exact fixed-point recurrence predicts each Q32.32
// value and the clip flag, and every output beat is checked against it in
// order. Both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import alag_pkg::*;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [63:0] poly_value;
    logic               saturated;
  } lag_result_t;

  localparam logic signed [127:0] Q64_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] Q64_MIN = -Q64_MAX - 128'sd1;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic             cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  alag_in_if  in_if ();
  alag_out_if out_if ();

  assoc_laguerre_polynomial_eval u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Register copies for the predictor
  logic signed [5:0] cfg_degree;
  logic        [5:0] cfg_order;

  lag_result_t pending_values[$];
  lag_result_t want;
  int          src_idle_pct;
  int          snk_idle_pct;
  int          error_count;
  int          samples_sent;
  int          clipped_seen;
  int          negdeg_seen;
  int          setting_count;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Evaluate L_n^m(x) with the same rounding and clipping as the hardware
  function automatic lag_result_t laguerre_eval(input logic signed [31:0] x);
    lag_result_t         r;
    int                  n;
    int                  m;
    logic        [63:0]  rq;
    logic signed [127:0] x_w;
    logic signed [127:0] prev;
    logic signed [127:0] cur;
    logic signed [127:0] a;
    logic signed [127:0] b;
    logic signed [127:0] s;
    logic signed [127:0] p;
    r.x          = x;
    r.saturated  = 1'b0;
    r.poly_value = ONE_Q32;
    n = int'(cfg_degree);
    m = int'(cfg_order);
    if (n < 0) begin
      r.poly_value = NEG_ONE_Q32;
      return r;
    end
    if (n > int'(MAX_DEGREE)) n = MAX_DEGREE;
    if (n == 0) return r;
    x_w  = x;
    prev = 128'sh1_0000_0000;
    cur  = (128'(m + 1) <<< 32) - (x_w <<< 16);
    for (int i = 2; i <= n; i++) begin
      a  = 128'((m + 2 * i - 1) * 65536) - x_w;
      b  = 128'((m + i - 1) * 65536);
      s  = a * cur - b * prev;
      s  = (s + 128'sd32768) >>> 16;
      rq = ((64'd1 << 32) + 64'(i >> 1)) / 64'(i);
      p  = (s * $signed({64'd0, rq}) + 128'sh8000_0000) >>> 32;
      prev = cur;
      if (p > Q64_MAX) begin
        cur = Q64_MAX;
        r.saturated = 1'b1;
      end else if (p < Q64_MIN) begin
        cur = Q64_MIN;
        r.saturated = 1'b1;
      end else begin
        cur = p;
      end
    end
    r.poly_value = cur[63:0];
    return r;
  endfunction

  // Output side: random backpressure, checked in order at the rising edge
  always @(negedge clk_i) out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_values.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual poly_value=%h saturated=%b",
                 $time, out_if.poly_value, out_if.saturated);
        error_count++;
      end else begin
        want = pending_values.pop_front();
        if (out_if.poly_value !== want.poly_value) begin
          $display("%0t: poly_value mismatch (x=%h): expected %h, actual %h",
                   $time, want.x, want.poly_value, out_if.poly_value);
          error_count++;
        end
        if (out_if.saturated !== want.saturated) begin
          $display("%0t: saturated mismatch (x=%h): expected %b, actual %b",
                   $time, want.x, want.saturated, out_if.saturated);
          error_count++;
        end
        if (want.saturated) clipped_seen++;
        if (want.poly_value == NEG_ONE_Q32) negdeg_seen++;
      end
    end
  end

  task automatic send_sample(input logic signed [31:0] x);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.sample_point <= x;
    do @(posedge clk_i); while (!in_if.ready);
    pending_values.push_back(laguerre_eval(x));
    samples_sent++;
  endtask

  // Hold the input quiet until every result is back
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    if (idx == REG_DEGREE) cfg_degree = val;
    else cfg_order = val;
  endtask

  task automatic set_config(input int deg, input int ord);
    drain_results();
    write_reg(REG_DEGREE, CFG_W'(deg));
    write_reg(REG_ORDER, CFG_W'(ord));
    setting_count++;
  endtask

  function automatic logic signed [31:0] random_point();
    logic signed [31:0] edges[8];
    edges = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, 32'sd1, -32'sd1,
              32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000};
    case ($urandom_range(0, 3))
      0: return $urandom;
      // span the region where the roots lie
      1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0010_0000;
      2: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      default: return edges[$urandom_range(0, 7)] ^ 32'($urandom_range(0, 3));
    endcase
  endfunction

  // Registers come out of reset as degree 0, order 0
  task automatic test_reset_state();
    send_sample(32'sd0);
    send_sample(32'sh0001_0000);
    send_sample(32'sh8000_0000);
  endtask

  task automatic test_special_degrees();
    set_config(-32, 0);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    set_config(-1, 63);
    send_sample(32'sd0);
    set_config(0, 63);
    send_sample(32'sh8000_0000);
    set_config(1, 0);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sd0);
    set_config(1, 63);
    send_sample(32'sh8000_0000);
  endtask

  task automatic test_deep_recurrence();
    set_config(31, 0);
    send_sample(32'sd0);
    send_sample(32'sh0001_0000);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    set_config(31, 63);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh0001_8000);
    set_config(2, 5);
    send_sample(-32'sd1);
    send_sample(32'sd1);
  endtask

  task automatic test_random_sweep();
    int deg;
    int sel;
    for (int phase = 0; phase < 34; phase++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) deg = -int'($urandom_range(1, 32));
      else if (sel == 1) deg = 0;
      else if (sel == 2) deg = MAX_DEGREE;
      else deg = $urandom_range(1, MAX_DEGREE);
      set_config(deg, $urandom_range(0, 63));
      // one long stretch with both sides running flat out
      if (phase >= 6 && phase < 10) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else begin
        src_idle_pct = 30;
        snk_idle_pct = 30;
      end
      for (int k = 0; k < 51; k++) begin
        if ($urandom_range(0, 39) == 0) drain_results();
        send_sample(random_point());
      end
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = REG_DEGREE;
    cfg_data           = '0;
    in_if.valid        = 1'b0;
    in_if.sample_point = '0;
    out_if.ready       = 1'b0;
    cfg_degree         = '0;
    cfg_order          = '0;
    src_idle_pct       = 30;
    snk_idle_pct       = 30;
    error_count        = 0;
    samples_sent       = 0;
    clipped_seen       = 0;
    negdeg_seen        = 0;
    setting_count      = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_special_degrees();
    test_deep_recurrence();
    test_random_sweep();

    drain_results();
    // catch any stray beat after the last expected one
    repeat (130) @(posedge clk_i);
    $display("Ran %0d sample points across %0d register settings.",
             samples_sent, setting_count);
    $display("%0d results clipped to 64 bits, %0d took the negative-degree path.",
             clipped_seen, negdeg_seen);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Timeout with %0d results outstanding", pending_values.size());
    $display("FAILURE");
    $finish;
  end

endmodule
